// File: rtl/wwr_pkg.sv
// Package with shared constants, types and character helpers for the find and replace block.
`timescale 1ns / 1ps
package wwr_pkg;

   localparam int PATTERN_MAX_DEF = 8;
   localparam int CHAR_W = 8;
   localparam int WORD_W = 64;
   localparam int LEN_W = 4;
   localparam int REP_MAX = 8;
   localparam int REP_IDX_W = 3;
   localparam int COUNT_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_CHARS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_CHARS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_LENGTH = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_REPLACE,
      ST_DROP
   } state_type;

   typedef struct packed {
      logic match;
      logic ident_at_len;
      logic ident_head;
   } cmp_result_type;

   function automatic logic is_ident(input logic [CHAR_W-1:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
   endfunction

   function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
   endfunction

endpackage

// File: rtl/wwr_if.sv
// Stream interfaces for the input characters and the rewritten characters.
`timescale 1ns / 1ps
interface wwr_req_if;
   logic valid;
   logic ready;
   logic [wwr_pkg::CHAR_W-1:0] in_char;
   logic in_last;

   modport source (output valid, output in_char, output in_last, input ready);
   modport sink (input valid, input in_char, input in_last, output ready);
endinterface

interface wwr_rsp_if;
   logic valid;
   logic ready;
   logic [wwr_pkg::CHAR_W-1:0] out_char;
   logic out_last;
   logic [wwr_pkg::COUNT_W-1:0] replace_total;

   modport source (output valid, output out_char, output out_last, output replace_total,
                   input ready);
   modport sink (input valid, input out_char, input out_last, input replace_total,
                 output ready);
endinterface

// File: rtl/wwr_cmp.sv
// Shared compare unit: matches the held window against the pattern and classifies characters.
`timescale 1ns / 1ps
module wwr_cmp #(
   parameter int PATTERN_MAX = wwr_pkg::PATTERN_MAX_DEF
) (
   input  logic [PATTERN_MAX:0][wwr_pkg::CHAR_W-1:0] win,
   input  logic [$clog2(PATTERN_MAX+2)-1:0]          fill,
   input  logic [$clog2(PATTERN_MAX+2)-1:0]          plen,
   input  logic [wwr_pkg::WORD_W-1:0]                pattern,
   output wwr_pkg::cmp_result_type                   result
);
   localparam int DEPTH = PATTERN_MAX + 1;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(PATTERN_MAX + 2);

   logic [PATTERN_MAX-1:0] eq;
   logic [DEPTH-1:0] ident;

   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         eq[i] = (CNT_W'(i) >= fill) || (CNT_W'(i) >= plen) ||
                 (wwr_pkg::fold(win[i]) == wwr_pkg::fold(pattern[i*8 +: 8]));
      end
      for (int i = 0; i < DEPTH; i++) begin
         ident[i] = wwr_pkg::is_ident(win[i]);
      end
      result.match = &eq;
      result.ident_at_len = ident[plen[IDX_W-1:0]];
      result.ident_head = ident[0];
   end

endmodule

// File: rtl/whole_word_replace_stream.sv
// Top level: whole-word, case-insensitive find and replace on a character stream.
//
//   Channel   Dir   Handshake          Payload
//   req_bus   in    valid/ready        in_char, in_last
//   rsp_bus   out   valid/ready        out_char, out_last, replace_total
//   csr_*     in    csr_we only        csr_index, csr_wdata
//
// An item is taken in ST_IDLE, then the sequencer works until the window is settled.
// Each released character takes a compare step in ST_EVAL; a replacement emits R characters in
// ST_REPLACE, then drops the L matched characters from the window in ST_DROP, all through one
// compare unit. Reset is synchronous and needs no clearing pass; a stalled output holds the
// sequencer.
`timescale 1ns / 1ps
module whole_word_replace_stream #(
   parameter int PATTERN_MAX = wwr_pkg::PATTERN_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   wwr_req_if.sink                             req_bus,
   wwr_rsp_if.source                           rsp_bus,
   input  logic                                csr_we,
   input  logic [wwr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wwr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   localparam int DEPTH = PATTERN_MAX + 1;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(PATTERN_MAX + 2);
   localparam int LEN_W = wwr_pkg::LEN_W;
   localparam int CHAR_W = wwr_pkg::CHAR_W;
   localparam int COUNT_W = wwr_pkg::COUNT_W;

   logic [wwr_pkg::WORD_W-1:0] pat_cfg_ff, rep_cfg_ff;
   logic [LEN_W-1:0] plen_cfg_ff, rlen_cfg_ff;

   logic [wwr_pkg::WORD_W-1:0] act_pat_ff, act_pat_in, act_rep_ff, act_rep_in;
   logic [CNT_W-1:0] act_plen_ff, act_plen_in;
   logic [LEN_W-1:0] act_rlen_ff, act_rlen_in;

   logic [DEPTH-1:0][CHAR_W-1:0] win_ff, win_in, win_shift;
   logic [CNT_W-1:0] fill_ff, fill_in, drop_ff, drop_in;
   logic last_ff, last_in;
   logic bound_ff, bound_in;
   logic [COUNT_W-1:0] count_ff, count_in, count_inc;
   logic [wwr_pkg::REP_IDX_W-1:0] rep_idx_ff, rep_idx_in;
   wwr_pkg::state_type state_ff, state_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0] rsp_total_ff, rsp_total_in;

   logic [CNT_W-1:0] plen_clamp;
   logic [LEN_W-1:0] rlen_clamp;
   logic out_free, pass, do_release, do_replace, right_ok, final_rep;
   wwr_pkg::cmp_result_type cmp;

   wwr_cmp #(.PATTERN_MAX(PATTERN_MAX)) u_cmp (
      .win     (win_ff),
      .fill    (fill_ff),
      .plen    (act_plen_ff),
      .pattern (act_pat_ff),
      .result  (cmp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_cfg_ff <= '0;
         plen_cfg_ff <= '0;
         rep_cfg_ff <= '0;
         rlen_cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            wwr_pkg::CSR_PATTERN_CHARS: pat_cfg_ff <= csr_wdata;
            wwr_pkg::CSR_PATTERN_LENGTH: plen_cfg_ff <= csr_wdata[LEN_W-1:0];
            wwr_pkg::CSR_REPLACEMENT_CHARS: rep_cfg_ff <= csr_wdata;
            wwr_pkg::CSR_REPLACEMENT_LENGTH: rlen_cfg_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wwr_pkg::ST_IDLE;
         act_pat_ff <= '0;
         act_rep_ff <= '0;
         act_plen_ff <= '0;
         act_rlen_ff <= '0;
         fill_ff <= '0;
         drop_ff <= '0;
         last_ff <= 1'b0;
         bound_ff <= 1'b1;
         count_ff <= '0;
         rep_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         act_pat_ff <= act_pat_in;
         act_rep_ff <= act_rep_in;
         act_plen_ff <= act_plen_in;
         act_rlen_ff <= act_rlen_in;
         fill_ff <= fill_in;
         drop_ff <= drop_in;
         last_ff <= last_in;
         bound_ff <= bound_in;
         count_ff <= count_in;
         rep_idx_ff <= rep_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_total_ff <= rsp_total_in;
   end

   always_comb begin
      plen_clamp = (plen_cfg_ff > LEN_W'(PATTERN_MAX)) ? CNT_W'(PATTERN_MAX)
                                                       : CNT_W'(plen_cfg_ff);
      rlen_clamp = (rlen_cfg_ff > LEN_W'(wwr_pkg::REP_MAX)) ? LEN_W'(wwr_pkg::REP_MAX)
                                                            : rlen_cfg_ff;
      count_inc = (count_ff == {COUNT_W{1'b1}}) ? count_ff : count_ff + 1'b1;
      for (int i = 0; i < DEPTH - 1; i++) begin
         win_shift[i] = win_ff[i+1];
      end
      win_shift[DEPTH-1] = win_ff[DEPTH-1];

      pass = (act_plen_ff == '0) || (act_rlen_ff == '0);
      do_release = 1'b0;
      do_replace = 1'b0;
      right_ok = 1'b0;
      if (fill_ff != '0) begin
         if (pass || !cmp.match) begin
            do_release = 1'b1;
         end else if (fill_ff < act_plen_ff) begin
            do_release = last_ff;
         end else if (fill_ff > act_plen_ff || last_ff) begin
            right_ok = (fill_ff > act_plen_ff) ? !cmp.ident_at_len : 1'b1;
            do_replace = bound_ff && right_ok;
            do_release = !(bound_ff && right_ok);
         end
      end
      final_rep = last_ff && (fill_ff == act_plen_ff) &&
                  ((LEN_W'(rep_idx_ff) + 1'b1) == act_rlen_ff);

      out_free = !rsp_valid_ff || rsp_bus.ready;

      state_in = state_ff;
      act_pat_in = act_pat_ff;
      act_rep_in = act_rep_ff;
      act_plen_in = act_plen_ff;
      act_rlen_in = act_rlen_ff;
      win_in = win_ff;
      fill_in = fill_ff;
      drop_in = drop_ff;
      last_in = last_ff;
      bound_in = bound_ff;
      count_in = count_ff;
      rep_idx_in = rep_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_total_in = rsp_total_ff;

      case (state_ff)
         wwr_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               if (fill_ff == '0) begin
                  act_pat_in = pat_cfg_ff;
                  act_rep_in = rep_cfg_ff;
                  act_plen_in = plen_clamp;
                  act_rlen_in = rlen_clamp;
               end
               win_in[fill_ff[IDX_W-1:0]] = req_bus.in_char;
               fill_in = fill_ff + 1'b1;
               last_in = req_bus.in_last;
               state_in = wwr_pkg::ST_EVAL;
            end
         end
         wwr_pkg::ST_EVAL: begin
            if (do_release) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in = win_ff[0];
                  rsp_last_in = last_ff && (fill_ff == CNT_W'(1));
                  rsp_total_in = (last_ff && (fill_ff == CNT_W'(1))) ? count_ff : '0;
                  bound_in = !cmp.ident_head;
                  win_in = win_shift;
                  fill_in = fill_ff - 1'b1;
               end
            end else if (do_replace) begin
               rep_idx_in = '0;
               state_in = wwr_pkg::ST_REPLACE;
            end else begin
               if (last_ff) begin
                  count_in = '0;
                  bound_in = 1'b1;
                  fill_in = '0;
               end
               state_in = wwr_pkg::ST_IDLE;
            end
         end
         wwr_pkg::ST_REPLACE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in = act_rep_ff[{rep_idx_ff, 3'b000} +: CHAR_W];
               rsp_last_in = final_rep;
               rsp_total_in = final_rep ? count_inc : '0;
               if ((LEN_W'(rep_idx_ff) + 1'b1) == act_rlen_ff) begin
                  count_in = count_inc;
                  bound_in = 1'b1;
                  drop_in = act_plen_ff;
                  state_in = wwr_pkg::ST_DROP;
               end else begin
                  rep_idx_in = rep_idx_ff + 1'b1;
               end
            end
         end
         wwr_pkg::ST_DROP: begin
            win_in = win_shift;
            fill_in = fill_ff - 1'b1;
            drop_in = drop_ff - 1'b1;
            if (drop_ff == CNT_W'(1)) begin
               state_in = wwr_pkg::ST_EVAL;
            end
         end
         default: begin
            state_in = wwr_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_bus.ready = (state_ff == wwr_pkg::ST_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_char = rsp_char_ff;
   assign rsp_bus.out_last = rsp_last_ff;
   assign rsp_bus.replace_total = rsp_total_ff;

endmodule

// File: rtl/wwr_checker.sv
// Port-level checker for the find and replace block, bound to the top level.
`timescale 1ns / 1ps
module wwr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [wwr_pkg::CHAR_W-1:0]   out_char,
   input logic                         out_last,
   input logic [wwr_pkg::COUNT_W-1:0]  replace_total
);

   // A stalled result item keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_char) && $stable(out_last)
                                  && $stable(replace_total))
      else $error("Stalled result item changed.");

   // The count is reported only on the final character of a string.
   a_total_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !out_last |-> replace_total == '0)
      else $error("Replacement count shown on a non-final item.");

   // The block works on an accepted item before it takes another.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Input accepted on consecutive cycles.");

   // A new result item appears only after the block has left the idle state to work on an item.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("Result item appeared without a work cycle.");

endmodule

bind whole_word_replace_stream wwr_checker u_wwr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .out_char      (rsp_bus.out_char),
   .out_last      (rsp_bus.out_last),
   .replace_total (rsp_bus.replace_total)
);
